// ----- hw/rtl/ctss_pkg.sv -----
// ----------------------------------------------------------------------------
// ctss_pkg
// Shared constants and decode functions for the countdown timer with
// multiplexed seven-segment scan.
// ----------------------------------------------------------------------------
package ctss_pkg;

  localparam int DIGIT_COUNT       = 4;
  localparam int SCAN_W            = $clog2(DIGIT_COUNT);
  localparam int DIGIT_W           = 4;
  localparam int TPS_W             = 10;
  localparam int SEG_W             = 7;
  localparam int MIN_W             = 7;
  localparam int SEC_W             = 6;
  localparam int START_MINUTES_DEF = 24;

  localparam logic [TPS_W-1:0] TPS_RESET = 10'd10;

  typedef logic [DIGIT_W-1:0] bcd_t;
  typedef logic [SCAN_W-1:0]  scan_t;

  // Segments a..g in bits 0..6, 1 = lit
  function automatic logic [SEG_W-1:0] seg_decode(input bcd_t d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h3F;
    endcase
    return s;
  endfunction

  // Scan position 0 is the units digit, which is the rightmost (bit 3)
  function automatic logic [DIGIT_COUNT-1:0] enable_decode(input scan_t p);
    logic [DIGIT_COUNT-1:0] e;
    unique case (p)
      2'd0:    e = 4'b0111;
      2'd1:    e = 4'b1011;
      2'd2:    e = 4'b1101;
      2'd3:    e = 4'b1110;
      default: e = 4'b0111;
    endcase
    return e;
  endfunction

endpackage

// ----- hw/rtl/ctss_digit_cell.sv -----
// ----------------------------------------------------------------------------
// ctss_digit_cell
// One BCD down-counting digit of the countdown chain; takes a borrow from
// the lower digit and passes one on when it wraps from zero.
// ----------------------------------------------------------------------------
module ctss_digit_cell
  import ctss_pkg::*;
#(
  parameter int MAX_DIGIT   = 9,
  parameter int RESET_DIGIT = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic borrow_in,
  output bcd_t digit,
  output bcd_t digit_nxt,
  output logic borrow_out
);

  bcd_t digit_r;

  always_comb begin
    digit_nxt  = digit_r;
    borrow_out = 1'b0;
    if (borrow_in) begin
      if (digit_r == '0) begin
        digit_nxt  = DIGIT_W'(MAX_DIGIT);
        borrow_out = 1'b1;
      end else begin
        digit_nxt = digit_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_r <= DIGIT_W'(RESET_DIGIT);
    end else begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

endmodule

// ----- hw/rtl/countdown_timer_seven_segment_scan.sv -----
// ----------------------------------------------------------------------------
// countdown_timer_seven_segment_scan
// Minutes:seconds countdown driving a four-digit multiplexed display.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_tick): each transaction is one
//   item; in_tick = 1 advances the prescaler and the digit scan, 0 only
//   reports the current state.
//   Result channel (out_valid / out_stall / out_*): one transaction per
//   input item, showing digit enable, segments, remaining time and expired,
//   all taken after the item's update.
//   Config channel (cfg_valid / cfg_ready / cfg_ticks_per_second): sets the
//   ticks that make one second; always ready. Write only while idle.
// Throughput: one item per cycle unless in_stall is high; a result appears
//   in the cycle after its item is accepted, from the output register.  The
//   time is held in a chain of four BCD digit cells with a ripple borrow.
// Reset: time is START_MINUTES:00, scan at the units digit, prescaler zero,
//   ticks per second 10, no result pending.
// Stall: while a held result is stalled the input side is stalled too; the
//   held result stays unchanged.
// ----------------------------------------------------------------------------
module countdown_timer_seven_segment_scan
  import ctss_pkg::*;
#(
  parameter int START_MINUTES = START_MINUTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_tick,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DIGIT_COUNT-1:0] out_digit_enable_n,
  output logic [SEG_W-1:0]       out_segment_pattern,
  output logic [MIN_W-1:0]       out_minutes_left,
  output logic [SEC_W-1:0]       out_seconds_left,
  output logic                   out_expired,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [TPS_W-1:0]       cfg_ticks_per_second
);

  localparam int START_UNITS = START_MINUTES % 10;
  localparam int START_TENS  = START_MINUTES / 10;

  logic             in_accept;
  logic             step;
  logic             sec_tick;
  logic             all_zero;
  logic [TPS_W-1:0] tps_r, tps_nxt;
  logic [TPS_W-1:0] sub_r, sub_nxt, sub_inc;
  scan_t            scan_r, scan_nxt;
  logic             out_valid_r, out_valid_nxt;

  bcd_t             dig     [DIGIT_COUNT];
  bcd_t             dig_nxt [DIGIT_COUNT];
  logic             borrow  [DIGIT_COUNT+1];

  logic [DIGIT_COUNT-1:0] en_r;
  logic [SEG_W-1:0]       seg_r;
  logic [MIN_W-1:0]       min_r, min_nxt;
  logic [SEC_W-1:0]       sec_r, sec_nxt;
  logic                   exp_r, exp_nxt;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign step      = in_accept & in_tick;
  assign cfg_ready = 1'b1;

  // Prescaler
  always_comb begin
    tps_nxt  = tps_r;
    if (cfg_valid) begin
      tps_nxt = cfg_ticks_per_second;
    end
    sub_inc  = sub_r + 1'b1;
    sec_tick = (sub_inc >= tps_r);
    sub_nxt  = sub_r;
    if (step) begin
      sub_nxt = sec_tick ? '0 : sub_inc;
    end
    scan_nxt = scan_r + SCAN_W'(step);
  end

  // Hold at 00:00: no borrow enters the chain
  assign all_zero  = (dig[0] == '0) && (dig[1] == '0) && (dig[2] == '0) && (dig[3] == '0);
  assign borrow[0] = step & sec_tick & ~all_zero;

  // Cells, units first: seconds units, seconds tens, minutes units, minutes tens
  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_cell
    localparam int MAXD = (i == 1) ? 5 : 9;
    localparam int RSTD = (i == 2) ? START_UNITS : ((i == 3) ? START_TENS : 0);
    ctss_digit_cell #(
      .MAX_DIGIT   (MAXD),
      .RESET_DIGIT (RSTD)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .borrow_in  (borrow[i]),
      .digit      (dig[i]),
      .digit_nxt  (dig_nxt[i]),
      .borrow_out (borrow[i+1])
    );
  end

  always_comb begin
    sec_nxt = SEC_W'({2'b0, dig_nxt[1]} * 6'd10) + SEC_W'(dig_nxt[0]);
    min_nxt = MIN_W'({3'b0, dig_nxt[3]} * 7'd10) + MIN_W'(dig_nxt[2]);
    exp_nxt = (dig_nxt[0] == '0) && (dig_nxt[1] == '0) &&
              (dig_nxt[2] == '0) && (dig_nxt[3] == '0);
    out_valid_nxt = in_accept | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= TPS_RESET;
      sub_r       <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tps_r       <= tps_nxt;
      sub_r       <= sub_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (in_accept) begin
      en_r  <= enable_decode(scan_nxt);
      seg_r <= seg_decode(dig_nxt[scan_nxt]);
      min_r <= min_nxt;
      sec_r <= sec_nxt;
      exp_r <= exp_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_digit_enable_n  = en_r;
  assign out_segment_pattern = seg_r;
  assign out_minutes_left    = min_r;
  assign out_seconds_left    = sec_r;
  assign out_expired         = exp_r;

endmodule

// ----- hw/rtl/ctss_checker.sv -----
// ----------------------------------------------------------------------------
// ctss_checker
// Port-level checks for the countdown timer, bound to the top level.
// ----------------------------------------------------------------------------
module ctss_checker
  import ctss_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [DIGIT_COUNT-1:0] out_digit_enable_n,
  input logic [SEG_W-1:0]       out_segment_pattern,
  input logic [MIN_W-1:0]       out_minutes_left,
  input logic [SEC_W-1:0]       out_seconds_left,
  input logic                   out_expired
);

  // Stalled result transaction must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digit_enable_n) &&
      $stable(out_segment_pattern) && $stable(out_minutes_left) &&
      $stable(out_seconds_left) && $stable(out_expired))
    else $error("result changed while stalled");

  a_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_expired == (out_minutes_left == '0 && out_seconds_left == '0))
    else $error("expired flag disagrees with remaining time");

  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_seconds_left <= SEC_W'(59) && out_minutes_left <= MIN_W'(99))
    else $error("remaining time out of range");

  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones(out_digit_enable_n) == DIGIT_COUNT - 1)
    else $error("not exactly one digit enabled");

endmodule

bind countdown_timer_seven_segment_scan ctss_checker u_ctss_checker (.*);

// ----- test/countdown_timer_seven_segment_scan_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_timer_seven_segment_scan_tb
// Self-checking bench for the minutes:seconds countdown with digit scan.
// A directed table covers reset state, scan order, out-of-range and extreme
// prescaler settings; random tick streams follow, then a run-down past 00:00.
// Each result is checked: typed rows against their entry, others against a timer model.
// ----------------------------------------------------------------------------
module countdown_timer_seven_segment_scan_tb;
  import ctss_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 60;
  localparam int REPORT_MAX     = 10;
  localparam int RANDOM_ITEMS   = 900;
  localparam int DIR_ROWS       = 17;

  // Segment glyphs for 0..9, digit d at bits [7*d +: 7]
  localparam logic [69:0] GLYPHS = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                    7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

  typedef struct packed {
    logic [DIGIT_COUNT-1:0] en_n;
    logic [SEG_W-1:0]       seg;
    logic [MIN_W-1:0]       mins;
    logic [SEC_W-1:0]       secs;
    logic                   zero;
  } display_t;

  typedef struct packed {
    logic             do_cfg;
    logic [TPS_W-1:0] rate;
    logic             tick;
    logic             typed;
    display_t         want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_tick = 1'b0;
  logic                   out_stall = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [TPS_W-1:0]       cfg_ticks_per_second = '0;
  logic                   in_stall;
  logic                   out_valid;
  logic [DIGIT_COUNT-1:0] out_digit_enable_n;
  logic [SEG_W-1:0]       out_segment_pattern;
  logic [MIN_W-1:0]       out_minutes_left;
  logic [SEC_W-1:0]       out_seconds_left;
  logic                   out_expired;
  logic                   cfg_ready;

  // Timer model state
  logic [TPS_W-1:0] tm_rate = TPS_RESET;
  logic [TPS_W-1:0] tm_sub = '0;
  logic [SEC_W-1:0] tm_sec = '0;
  logic [MIN_W-1:0] tm_min = MIN_W'(START_MINUTES_DEF);
  logic [1:0]       tm_scan = '0;

  display_t display_expect_q[$];
  int       bad_results = 0;
  int       results_seen = 0;
  int       quiet_cycles = 0;
  int       src_gap_pct = 0;
  int       sink_hold_pct = 0;
  int       hold_left = 0;
  bit       hold_armed = 1'b1;
  bit       row_typed = 1'b0;
  display_t row_want = '0;

  countdown_timer_seven_segment_scan u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_tick              (in_tick),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_digit_enable_n   (out_digit_enable_n),
    .out_segment_pattern  (out_segment_pattern),
    .out_minutes_left     (out_minutes_left),
    .out_seconds_left     (out_seconds_left),
    .out_expired          (out_expired),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_ticks_per_second (cfg_ticks_per_second)
  );

  always #5 clk = ~clk;

  // Advance the timer model by one input transaction and form its display
  task automatic advance_timer(input logic t, output display_t r);
    int number;
    int place;
    int dig;
    if (t) begin
      tm_sub = tm_sub + 1'b1;
      if (tm_sub >= tm_rate) begin
        tm_sub = '0;
        if (tm_sec != 0) begin
          tm_sec = tm_sec - 1'b1;
        end else if (tm_min != 0) begin
          tm_min = tm_min - 1'b1;
          tm_sec = 6'd59;
        end
      end
      tm_scan = tm_scan + 1'b1;
    end
    number = (int'(tm_min) * 100 + int'(tm_sec)) % 10000;
    place = 1;
    for (int i = 0; i < int'(tm_scan); i++) place = place * 10;
    dig = (number / place) % 10;
    r.en_n = 4'hF;
    r.en_n[3 - tm_scan] = 1'b0;
    r.seg = GLYPHS[dig*7 +: 7];
    r.mins = tm_min;
    r.secs = tm_sec;
    r.zero = (tm_min == 0) && (tm_sec == 0);
  endtask

  task automatic show_mismatch(input string what, input display_t want, input display_t got);
    if (bad_results < REPORT_MAX) begin
      $display("%0t %s: expected en=%b seg=%h min=%0d sec=%0d exp=%b,",
               $time, what, want.en_n, want.seg, want.mins, want.secs, want.zero);
      $display("    got en=%b seg=%h min=%0d sec=%0d exp=%b",
               got.en_n, got.seg, got.mins, got.secs, got.zero);
    end
    bad_results++;
  endtask

  // Scoreboard and watchdog; owns the timer model
  always @(posedge clk) begin : monitor
    display_t got;
    display_t want;
    display_t pred;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        tm_rate = cfg_ticks_per_second;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got = {out_digit_enable_n, out_segment_pattern, out_minutes_left,
               out_seconds_left, out_expired};
        results_seen++;
        moved = 1'b1;
        if (display_expect_q.size() == 0) begin
          show_mismatch("unexpected result", '0, got);
        end else begin
          want = display_expect_q.pop_front();
          if (got.en_n !== want.en_n || got.seg !== want.seg || got.mins !== want.mins ||
              got.secs !== want.secs || got.zero !== want.zero)
            show_mismatch("result mismatch", want, got);
        end
      end
      if (in_valid && !in_stall) begin
        advance_timer(in_tick, pred);
        display_expect_q.push_back(row_typed ? row_want : pred);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Result side: random stalls plus one long hold-off while items are offered
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_armed && results_seen >= 150 && in_valid) begin
      hold_armed <= 1'b0;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < sink_hold_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_tick(input logic t);
    while ($urandom_range(0, 99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_tick <= t;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Sender pauses until every result is back, then writes the prescaler
  task automatic set_rate(input logic [TPS_W-1:0] rate);
    in_valid <= 1'b0;
    while (display_expect_q.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_ticks_per_second <= rate;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TPS_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 10'd1;
      2:       return 10'd1000;
      3:       return 10'd1023;
      4:       return TPS_W'($urandom_range(1, 1023));
      5, 6:    return TPS_W'($urandom_range(2, 4));
      default: return TPS_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_gap_pct = src_pct;
    sink_hold_pct = sink_pct;
  endtask

  dir_row_t dir_rows [DIR_ROWS] = '{
    // reset state, scan walks 2400 units digit first
    '{1'b0, 10'd0,    1'b0, 1'b1, '{4'b0111, 7'h3F, 7'd24, 6'd0, 1'b0}},
    '{1'b0, 10'd0,    1'b1, 1'b1, '{4'b1011, 7'h3F, 7'd24, 6'd0, 1'b0}},
    '{1'b0, 10'd0,    1'b1, 1'b1, '{4'b1101, 7'h66, 7'd24, 6'd0, 1'b0}},
    '{1'b0, 10'd0,    1'b1, 1'b1, '{4'b1110, 7'h5B, 7'd24, 6'd0, 1'b0}},
    '{1'b0, 10'd0,    1'b1, 1'b1, '{4'b0111, 7'h3F, 7'd24, 6'd0, 1'b0}},
    // zero ticks per second: every tick is a second, first one borrows
    '{1'b1, 10'd0,    1'b1, 1'b0, '0},
    '{1'b0, 10'd0,    1'b0, 1'b0, '0},
    '{1'b0, 10'd0,    1'b1, 1'b0, '0},
    // slowest legal prescaler
    '{1'b1, 10'd1000, 1'b1, 1'b0, '0},
    '{1'b0, 10'd0,    1'b1, 1'b0, '0},
    '{1'b0, 10'd0,    1'b1, 1'b0, '0},
    // lowered below the running subtick: second ends on next tick
    '{1'b1, 10'd1,    1'b1, 1'b0, '0},
    '{1'b0, 10'd0,    1'b1, 1'b0, '0},
    // all-ones register
    '{1'b1, 10'd1023, 1'b1, 1'b0, '0},
    '{1'b0, 10'd0,    1'b0, 1'b0, '0},
    '{1'b0, 10'd0,    1'b1, 1'b0, '0},
    '{1'b1, 10'd2,    1'b1, 1'b0, '0}
  };

  initial begin : stimulus
    int sent;
    int len;
    int extra;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_idling(35, 62);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].do_cfg) set_rate(dir_rows[i].rate);
      row_typed = dir_rows[i].typed;
      row_want = dir_rows[i].want;
      send_tick(dir_rows[i].tick);
    end
    row_typed = 1'b0;

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) set_idling(35, 62);
      else if (sent < 2 * RANDOM_ITEMS / 3) set_idling(62, 35);
      else set_idling(0, 0);
      set_rate(pick_rate());
      len = $urandom_range(20, 80);
      for (int i = 0; i < len; i++) begin
        send_tick($urandom_range(0, 99) < 75);
        sent++;
      end
    end

    // Run the count down to 00:00 and keep ticking there
    set_rate(10'd1);
    extra = 0;
    while (extra < 100) begin
      send_tick($urandom_range(0, 99) < 90);
      if (tm_min == 0 && tm_sec == 0) extra++;
    end
    set_rate('0);
    for (int i = 0; i < 40; i++) send_tick(1'($urandom_range(0, 1)));
    set_rate(10'd3);
    for (int i = 0; i < 40; i++) send_tick(1'($urandom_range(0, 1)));

    in_valid <= 1'b0;
    while (display_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
    if (bad_results == 0 && display_expect_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (display_expect_q.size() != 0)
        $display("%0d expected results never arrived", display_expect_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ctss_pkg.sv
hw/rtl/ctss_digit_cell.sv
hw/rtl/countdown_timer_seven_segment_scan.sv
hw/rtl/ctss_checker.sv
test/countdown_timer_seven_segment_scan_tb.sv
